/* rtl/kct_pkg.sv */
`timescale 1ns / 1ps

package kct_pkg;

  localparam int DEFAULT_MAX_VEHICLES = 8;
  localparam int VEH_W = 3;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

  localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET     = 31'd66;
  localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RESET = 31'd6554;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // quotient is 48 bits, two bits retired per cycle
  localparam int DIV_BITS  = 48;
  localparam int DIV_STEPS = DIV_BITS / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_M_DT2     = 5'd2;
  localparam logic [OP_W-1:0] OP_M_DTV     = 5'd3;
  localparam logic [OP_W-1:0] OP_M_DTP     = 5'd4;
  localparam logic [OP_W-1:0] OP_M_DT2P11  = 5'd5;
  localparam logic [OP_W-1:0] OP_M_DTP11   = 5'd6;
  localparam logic [OP_W-1:0] OP_H         = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV0      = 5'd8;
  localparam logic [OP_W-1:0] OP_W0        = 5'd9;
  localparam logic [OP_W-1:0] OP_DIV1      = 5'd10;
  localparam logic [OP_W-1:0] OP_W1        = 5'd11;
  localparam logic [OP_W-1:0] OP_M_K0Z     = 5'd12;
  localparam logic [OP_W-1:0] OP_M_K1Z     = 5'd13;
  localparam logic [OP_W-1:0] OP_M_K0H00   = 5'd14;
  localparam logic [OP_W-1:0] OP_M_K0H01   = 5'd15;
  localparam logic [OP_W-1:0] OP_M_K1H00   = 5'd16;
  localparam logic [OP_W-1:0] OP_M_K1H01   = 5'd17;
  localparam logic [OP_W-1:0] OP_FIN_UPD   = 5'd18;
  localparam logic [OP_W-1:0] OP_FIN_PASS  = 5'd19;

  typedef struct packed {
    logic [VEH_W-1:0]   vehicle;
    logic               restart;
    logic               sample_valid;
    logic signed [31:0] distance;
    logic signed [31:0] lateral_velocity;
    logic [15:0]        time_step;
  } kct_in_t;

  typedef struct packed {
    logic [VEH_W-1:0]   vehicle_out;
    logic signed [31:0] distance_est;
    logic signed [31:0] velocity_est;
    logic               updated;
  } kct_out_t;

  typedef struct packed {
    logic signed [31:0] pd;
    logic signed [31:0] pv;
    logic signed [31:0] c00;
    logic signed [31:0] c01;
    logic signed [31:0] c10;
    logic signed [31:0] c11;
  } track_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } kct_cmd_t;

  typedef struct packed {
    logic do_update;
    logic s_pos;
    logic div_done;
    logic out_free;
  } kct_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32_MAX)) r = S32_MAX;
    else if (v < 64'(S32_MIN)) r = S32_MIN;
    else r = 32'(v);
    return r;
  endfunction

endpackage

/* rtl/kct_div.sv */
`timescale 1ns / 1ps

module kct_div import kct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [30:0]        den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [31:0]          rem;
  logic [DIV_BITS-1:0]  qr;
  logic [31:0]          dext;
  logic [31:0]          nabs;
  logic [31:0]          sh1, r1, sh2, r2;
  logic                 ge1, ge2;
  logic [DIV_BITS-1:0]  q1, q2;
  logic signed [48:0]   qs;

  assign dext = {1'b0, den};
  assign nabs = num[31] ? 32'(-num) : 32'(num);

  always_comb begin
    sh1 = {rem[30:0], qr[DIV_BITS-1]};
    ge1 = sh1 >= dext;
    r1  = ge1 ? sh1 - dext : sh1;
    q1  = {qr[DIV_BITS-2:0], ge1};
    sh2 = {r1[30:0], q1[DIV_BITS-1]};
    ge2 = sh2 >= dext;
    r2  = ge2 ? sh2 - dext : sh2;
    q2  = {q1[DIV_BITS-2:0], ge2};
  end

  assign qs  = neg ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
  assign quo = sat32(64'(qs));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[31];
      rem <= '0;
      qr  <= {nabs, 16'd0};
    end else if (busy) begin
      rem <= r2;
      qr  <= q2;
    end
  end

endmodule

/* rtl/kct_datapath.sv */
`timescale 1ns / 1ps

module kct_datapath import kct_pkg::*; #(
  parameter int MAX_VEHICLES = DEFAULT_MAX_VEHICLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kct_cmd_t             cmd,
  output kct_status_t          status,
  input  kct_in_t              req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output kct_out_t             rsp_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;

  logic [CFG_W-1:0]   process_noise;
  logic [CFG_W-1:0]   measurement_noise;
  kct_in_t            in_q;
  track_t             trk_q;
  track_t             track_mem [MAX_VEHICLES];
  logic [MAX_VEHICLES-1:0] prior_valid;
  logic signed [65:0] prod;
  logic [15:0]        dt2;
  logic signed [31:0] xh0, h00, h01, h10, h11, s, z, k0, k1, od, ov, c00, c01, c10;
  logic signed [63:0] acc;

  logic [IDX_W-1:0]   idx_q;
  logic               in_range;
  logic signed [63:0] psh, q64, r64;
  logic signed [32:0] ma, mb;
  logic               mul_en;
  logic signed [32:0] dt_op, dt2_op, psum;
  logic signed [31:0] c11_new;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quo;
  logic signed [31:0] div_num;
  logic               fin;

  assign idx_q    = IDX_W'(in_q.vehicle);
  assign in_range = 32'(in_q.vehicle) < 32'(MAX_VEHICLES);
  assign psh      = 64'(prod >>> 16);
  assign q64      = 64'($signed({1'b0, process_noise}));
  assign r64      = 64'($signed({1'b0, measurement_noise}));
  assign dt_op    = $signed({17'd0, in_q.time_step});
  assign dt2_op   = $signed({17'd0, dt2});
  assign psum     = 33'(trk_q.c01) + 33'(trk_q.c10);
  assign c11_new  = sat32(64'(h11) - psh);
  assign fin      = (cmd.op == OP_FIN_UPD) || (cmd.op == OP_FIN_PASS);

  assign div_start = (cmd.op == OP_DIV0) || (cmd.op == OP_DIV1);
  assign div_num   = (cmd.op == OP_DIV1) ? h10 : h00;

  kct_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s[30:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    status.do_update = in_range && !in_q.restart && in_q.sample_valid && prior_valid[idx_q];
    status.s_pos     = !s[31] && (s != '0);
    status.div_done  = div_done;
    status.out_free  = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_M_DT2:    begin ma = dt_op;      mb = dt_op;           end
      OP_M_DTV:    begin ma = dt_op;      mb = 33'(trk_q.pv);   end
      OP_M_DTP:    begin ma = dt_op;      mb = psum;            end
      OP_M_DT2P11: begin ma = dt2_op;     mb = 33'(trk_q.c11);  end
      OP_M_DTP11:  begin ma = dt_op;      mb = 33'(trk_q.c11);  end
      OP_M_K0Z:    begin ma = 33'(k0);    mb = 33'(z);          end
      OP_M_K1Z:    begin ma = 33'(k1);    mb = 33'(z);          end
      OP_M_K0H00:  begin ma = 33'(k0);    mb = 33'(h00);        end
      OP_M_K0H01:  begin ma = 33'(k0);    mb = 33'(h01);        end
      OP_M_K1H00:  begin ma = 33'(k1);    mb = 33'(h00);        end
      OP_M_K1H01:  begin ma = 33'(k1);    mb = 33'(h01);        end
      default:     mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= PROCESS_NOISE_RESET;
      measurement_noise <= MEASUREMENT_NOISE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROCESS_NOISE:     process_noise     <= cfg_data;
        REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_q  <= req_data;
        trk_q <= track_mem[IDX_W'(req_data.vehicle)];
      end
      OP_M_DTV:    dt2 <= prod[31:16];
      OP_M_DTP:    xh0 <= sat32(64'(trk_q.pd) + psh);
      OP_M_DT2P11: acc <= 64'(trk_q.c00) + psh + q64;
      OP_M_DTP11:  h00 <= sat32(acc + psh);
      OP_H: begin
        h01 <= sat32(64'(trk_q.c01) + psh);
        h10 <= sat32(64'(trk_q.c10) + psh);
        h11 <= sat32(64'(trk_q.c11) + q64);
        s   <= sat32(64'(h00) + r64);
        z   <= sat32(64'(in_q.distance) - 64'(xh0));
      end
      OP_W0: if (div_done) k0 <= div_quo;
      OP_W1: if (div_done) k1 <= div_quo;
      OP_M_K1Z:   od  <= sat32(64'(xh0) + psh);
      OP_M_K0H00: ov  <= sat32(64'(trk_q.pv) + psh);
      OP_M_K0H01: c00 <= sat32(64'(h00) - psh);
      OP_M_K1H00: c01 <= sat32(64'(h01) - psh);
      OP_M_K1H01: c10 <= sat32(64'(h10) - psh);
      OP_FIN_UPD: begin
        track_mem[idx_q] <= '{pd: od, pv: ov, c00: c00, c01: c01, c10: c10, c11: c11_new};
        rsp_data <= '{vehicle_out: in_q.vehicle, distance_est: od,
                      velocity_est: ov, updated: 1'b1};
      end
      OP_FIN_PASS: begin
        if (in_range) begin
          track_mem[idx_q] <= '{pd: in_q.distance, pv: in_q.lateral_velocity,
                                c00: ONE_Q16, c01: ONE_Q16, c10: ONE_Q16, c11: ONE_Q16};
        end
        rsp_data <= '{vehicle_out: in_q.vehicle, distance_est: in_q.distance,
                      velocity_est: in_q.lateral_velocity, updated: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_valid <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (fin) begin
        rsp_valid <= 1'b1;
        if (in_range) prior_valid[idx_q] <= in_q.sample_valid;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/kct_ctrl.sv */
`timescale 1ns / 1ps

module kct_ctrl import kct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  output kct_cmd_t    cmd,
  input  kct_status_t status
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DT2      = 5'd1;
  localparam logic [4:0] S_DTV      = 5'd2;
  localparam logic [4:0] S_DTP      = 5'd3;
  localparam logic [4:0] S_DT2P11   = 5'd4;
  localparam logic [4:0] S_DTP11    = 5'd5;
  localparam logic [4:0] S_H        = 5'd6;
  localparam logic [4:0] S_DIV0     = 5'd7;
  localparam logic [4:0] S_W0       = 5'd8;
  localparam logic [4:0] S_DIV1     = 5'd9;
  localparam logic [4:0] S_W1       = 5'd10;
  localparam logic [4:0] S_K0Z      = 5'd11;
  localparam logic [4:0] S_K1Z      = 5'd12;
  localparam logic [4:0] S_K0H00    = 5'd13;
  localparam logic [4:0] S_K0H01    = 5'd14;
  localparam logic [4:0] S_K1H00    = 5'd15;
  localparam logic [4:0] S_K1H01    = 5'd16;
  localparam logic [4:0] S_FIN_UPD  = 5'd17;
  localparam logic [4:0] S_FIN_PASS = 5'd18;

  logic [4:0] state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: if (req_valid) begin
        cmd.op     = OP_LOAD;
        state_next = S_DT2;
      end
      S_DT2: begin
        cmd.op     = OP_M_DT2;
        state_next = status.do_update ? S_DTV : S_FIN_PASS;
      end
      S_DTV:    begin cmd.op = OP_M_DTV;    state_next = S_DTP;    end
      S_DTP:    begin cmd.op = OP_M_DTP;    state_next = S_DT2P11; end
      S_DT2P11: begin cmd.op = OP_M_DT2P11; state_next = S_DTP11;  end
      S_DTP11:  begin cmd.op = OP_M_DTP11;  state_next = S_H;      end
      S_H:      begin cmd.op = OP_H;        state_next = S_DIV0;   end
      S_DIV0: begin
        if (status.s_pos) begin
          cmd.op     = OP_DIV0;
          state_next = S_W0;
        end else begin
          state_next = S_FIN_PASS;
        end
      end
      S_W0: begin
        cmd.op = OP_W0;
        if (status.div_done) state_next = S_DIV1;
      end
      S_DIV1: begin cmd.op = OP_DIV1; state_next = S_W1; end
      S_W1: begin
        cmd.op = OP_W1;
        if (status.div_done) state_next = S_K0Z;
      end
      S_K0Z:    begin cmd.op = OP_M_K0Z;   state_next = S_K1Z;     end
      S_K1Z:    begin cmd.op = OP_M_K1Z;   state_next = S_K0H00;   end
      S_K0H00:  begin cmd.op = OP_M_K0H00; state_next = S_K0H01;   end
      S_K0H01:  begin cmd.op = OP_M_K0H01; state_next = S_K1H00;   end
      S_K1H00:  begin cmd.op = OP_M_K1H00; state_next = S_K1H01;   end
      S_K1H01:  begin cmd.op = OP_M_K1H01; state_next = S_FIN_UPD; end
      S_FIN_UPD: if (status.out_free) begin
        cmd.op     = OP_FIN_UPD;
        state_next = S_IDLE;
      end
      S_FIN_PASS: if (status.out_free) begin
        cmd.op     = OP_FIN_PASS;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

/* rtl/kalman_cv_track_filter.sv */
`timescale 1ns / 1ps
// Two-state constant-velocity track filter, one track per vehicle index.
// Request channel: req_valid / req_stall / req_data (kct_in_t). A transaction
// is taken when req_valid is high and req_stall low; req_stall stays high
// while one transaction is being worked on.
// Response channel: rsp_valid / rsp_stall / rsp_data (kct_out_t), one
// response per request, held in an output register while rsp_stall is high.
// A new request can be taken while a response still waits.
// A pass-through goes from accept through the DT2 step to the final step; a
// non-positive innovation variance ends as a pass-through after the H and
// DIV0 steps; a filter update uses two radix-4 divisions for the gains and
// eleven passes through the single shared 33x33 multiplier.
// If the response register is still full when a result is ready, the block
// holds in its last state until the register frees.
// Config: cfg_we writes cfg_data to register cfg_index (0 process noise,
// 1 measurement noise). The user must write only while idle (not enforced).
// Reset (rst, synchronous): all tracks marked invalid, noise registers to
// their defaults, both channels empty.
module kalman_cv_track_filter import kct_pkg::*; #(
  parameter int MAX_VEHICLES = DEFAULT_MAX_VEHICLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  kct_in_t              req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output kct_out_t             rsp_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  kct_cmd_t    cmd;
  kct_status_t status;

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .status    (status)
  );

  kct_datapath #(.MAX_VEHICLES(MAX_VEHICLES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* rtl/kct_checker.sv */
`timescale 1ns / 1ps

module kct_checker import kct_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input kct_out_t             rsp_data
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("channels not empty after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second transaction taken while busy");

  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without a transaction in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

endmodule

bind kalman_cv_track_filter kct_checker u_kct_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import kct_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  kct_in_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  kct_out_t rsp_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PROCESS_NOISE;
  logic [CFG_W-1:0] cfg_data = '0;

  kalman_cv_track_filter dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // track state mirror
  longint q_noise, r_noise;
  longint trk_d [8];
  longint trk_v [8];
  bit trk_ok [8];
  longint trk_p [8][4];

  kct_out_t est_q [$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic void clear_tracks();
    q_noise = 66;
    r_noise = 6554;
    for (int n = 0; n < 8; n++) begin
      trk_d[n] = 0;
      trk_v[n] = 0;
      trk_ok[n] = 0;
      for (int k = 0; k < 4; k++) trk_p[n][k] = 65536;
    end
  endfunction

  function automatic kct_out_t track_update(kct_in_t t);
    kct_out_t o;
    int n;
    longint dt, dt2, xh0, xh1, h00, h01, h10, h11, s, k0, k1, z, od, ov, p00, p01, p10, p11;
    bit upd;
    n = int'(t.vehicle);
    dt = longint'(t.time_step);
    od = longint'(t.distance);
    ov = longint'(t.lateral_velocity);
    upd = 0;
    if (!t.restart && t.sample_valid && trk_ok[n]) begin
      p00 = trk_p[n][0]; p01 = trk_p[n][1]; p10 = trk_p[n][2]; p11 = trk_p[n][3];
      dt2 = (dt * dt) >>> 16;
      xh0 = sat(trk_d[n] + fmul(dt, trk_v[n]));
      xh1 = trk_v[n];
      h00 = sat(p00 + fmul(dt, p01 + p10) + fmul(dt2, p11) + q_noise);
      h01 = sat(p01 + fmul(dt, p11));
      h10 = sat(p10 + fmul(dt, p11));
      h11 = sat(p11 + q_noise);
      s = sat(h00 + r_noise);
      if (s > 0) begin
        k0 = sat((h00 * 65536) / s);
        k1 = sat((h10 * 65536) / s);
        z = sat(longint'(t.distance) - xh0);
        od = sat(xh0 + fmul(k0, z));
        ov = sat(xh1 + fmul(k1, z));
        trk_p[n][0] = sat(h00 - fmul(k0, h00));
        trk_p[n][1] = sat(h01 - fmul(k0, h01));
        trk_p[n][2] = sat(h10 - fmul(k1, h00));
        trk_p[n][3] = sat(h11 - fmul(k1, h01));
        upd = 1;
      end
    end
    if (!upd) for (int k = 0; k < 4; k++) trk_p[n][k] = 65536;
    trk_d[n] = od;
    trk_v[n] = ov;
    trk_ok[n] = t.sample_valid;
    o.vehicle_out = t.vehicle;
    o.distance_est = od[31:0];
    o.velocity_est = ov[31:0];
    o.updated = upd;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // response checker and stall pattern
  always @(posedge clk) begin
    kct_out_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (est_q.size() == 0) report("unexpected transaction", 0, 0);
      else begin
        want = est_q.pop_front();
        if (rsp_data.vehicle_out !== want.vehicle_out)
          report("vehicle_out", rsp_data.vehicle_out, want.vehicle_out);
        if (rsp_data.distance_est !== want.distance_est)
          report("distance_est", rsp_data.distance_est, want.distance_est);
        if (rsp_data.velocity_est !== want.velocity_est)
          report("velocity_est", rsp_data.velocity_est, want.velocity_est);
        if (rsp_data.updated !== want.updated)
          report("updated", rsp_data.updated, want.updated);
      end
    end
    if (hold_off) rsp_stall <= 1'b1;
    else if (cycles[9]) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic send(kct_in_t t);
    if (gap_left == 0 && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
    end
    if (gap_left > 0) req_valid <= 1'b0;
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    if (burst_left > 0) burst_left--;
    req_valid <= 1'b1;
    req_data <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    est_q.push_back(track_update(t));
  endtask

  task automatic drain();
    int guard;
    req_valid <= 1'b0;
    guard = 0;
    while (est_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (est_q.size() != 0) report("missing transaction", est_q.size(), 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PROCESS_NOISE) q_noise = val & 64'h7FFF_FFFF;
    else r_noise = val & 64'h7FFF_FFFF;
    @(posedge clk);
  endtask

  function automatic kct_in_t mk(int n, bit rs, bit sv, longint d, longint v, int dt);
    kct_in_t t;
    t.vehicle = n[VEH_W-1:0];
    t.restart = rs;
    t.sample_valid = sv;
    t.distance = d[31:0];
    t.lateral_velocity = v[31:0];
    t.time_step = dt[15:0];
    return t;
  endfunction

  function automatic longint rnd32();
    case ($urandom_range(0, 5))
      0: return -64'sd2147483648;
      1: return 64'sd2147483647;
      2: return longint'($signed($urandom()));
      default: return longint'($signed($urandom_range(0, 2000000))) - 1000000;
    endcase
  endfunction

  function automatic kct_in_t rand_item();
    int n;
    n = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0)
      return mk(n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rnd32(), rnd32(),
                $urandom_range(0, 65535));
    return mk(n, $urandom_range(0, 30) == 0, $urandom_range(0, 20) != 0,
              longint'($signed($urandom_range(0, 4000000))) - 2000000 + n * 100000,
              longint'($signed($urandom_range(0, 200000))) - 100000,
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(3000, 7000));
  endfunction

  task automatic test_directed();
    send(mk(0, 1, 1, 64'sd2147483647, -64'sd2147483648, 0));
    send(mk(0, 0, 1, 64'sd2147483647, 0, 65535));
    send(mk(0, 0, 1, -64'sd2147483648, 0, 65535));
    send(mk(1, 0, 1, 100000, 5000, 6554));
    send(mk(1, 0, 1, 110000, 5000, 6554));
    send(mk(1, 0, 0, -1, -1, 65535));
    send(mk(1, 0, 1, 120000, 0, 6554));
    send(mk(7, 0, 1, 1, 1, 1));
    send(mk(7, 0, 1, 2, 2, 0));
    send(mk(7, 1, 1, 3, 3, 100));
    send(mk(7, 0, 1, 4, 4, 65535));
    drain();
  endtask

  task automatic test_noise_extremes();
    // max q saturates P and S; S goes non-positive with near-max noise and negative h00
    write_reg(REG_PROCESS_NOISE, 64'd2147483647);
    write_reg(REG_MEASUREMENT_NOISE, 1);
    for (int i = 0; i < 12; i++) send(mk(2, i == 0, 1, i * 70000, 1000, 65535));
    drain();
    write_reg(REG_PROCESS_NOISE, 0);
    write_reg(REG_MEASUREMENT_NOISE, 64'd2147483647);
    for (int i = 0; i < 12; i++) send(mk(3, i == 0, 1, -i * 70000, -2000, 32768));
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send(rand_item());
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send(mk(i % 8, 1, 1, i, -i, 0));
    join
    drain();
  endtask

  initial begin
    clear_tracks();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_noise_extremes();
    write_reg(REG_PROCESS_NOISE, 66);
    write_reg(REG_MEASUREMENT_NOISE, 6554);
    test_random(500);
    test_backpressure();
    write_reg(REG_PROCESS_NOISE, 2000);
    write_reg(REG_MEASUREMENT_NOISE, 300);
    test_random(500);
    write_reg(REG_PROCESS_NOISE, $urandom_range(0, 32'h7FFF_FFFF));
    write_reg(REG_MEASUREMENT_NOISE, $urandom_range(1, 1000000));
    test_random(500);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

/* files.f */
rtl/kct_pkg.sv
rtl/kct_div.sv
rtl/kct_datapath.sv
rtl/kct_ctrl.sv
rtl/kalman_cv_track_filter.sv
rtl/kct_checker.sv
bench/testbench.sv
